// ===== rtl/core/c2e_pkg.sv =====
// Shared constants and the month table for the calendar to epoch seconds converter.
`timescale 1ns / 1ps

package c2e_pkg;

  localparam int YEAR_BITS_DEF  = 16;
  localparam int MONTH_W        = 4;
  localparam int DAY_W          = 6;
  localparam int HOUR_W         = 5;
  localparam int MINUTE_W       = 6;
  localparam int SECOND_W       = 6;
  localparam int NS_W           = 30;
  localparam int SECS_W         = 42;

  localparam int EPOCH_YEAR     = 1970;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int SECS_PER_HOUR  = 3600;
  localparam int SECS_PER_MIN   = 60;
  // 86400 seconds per day, split as 675 times 128.
  localparam int DAY_SECS_ODD   = 675;
  localparam int DAY_SECS_SHIFT = 7;
  localparam int DAY_SECS_ODD_W = 10;
  localparam int TOD_W          = 17;
  localparam int DOY_W          = 9;
  localparam int LEAP_MONTH     = 3;
  localparam int MONTHS         = 12;

  // Leap-day counts of the year before the epoch year.
  localparam int Q4_BASE        = (EPOCH_YEAR - 1) / 4;
  localparam int Q100_BASE      = (EPOCH_YEAR - 1) / 100;
  localparam int Q400_BASE      = (EPOCH_YEAR - 1) / 400;

  typedef logic [DOY_W-1:0] doy_t;

  // Days in the year before the first of the month; index is month minus one.
  function automatic doy_t days_before_month(input logic [MONTH_W-1:0] idx);
    doy_t d;
    case (idx)
      4'd0:    d = doy_t'(0);
      4'd1:    d = doy_t'(31);
      4'd2:    d = doy_t'(59);
      4'd3:    d = doy_t'(90);
      4'd4:    d = doy_t'(120);
      4'd5:    d = doy_t'(151);
      4'd6:    d = doy_t'(181);
      4'd7:    d = doy_t'(212);
      4'd8:    d = doy_t'(243);
      4'd9:    d = doy_t'(273);
      4'd10:   d = doy_t'(304);
      4'd11:   d = doy_t'(334);
      default: d = doy_t'(0);
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/calendar_to_epoch_seconds.sv =====
// Five-stage pipeline that turns a Gregorian date and time into Unix seconds.
`timescale 1ns / 1ps

//  channel  direction  ports                                         flow control
//  in       input      in_year/month/day/hour/minute/second/nanosecond  in_valid, in_stall
//  out      output     out_epoch_seconds, out_nanoseconds_out         out_valid, out_stall
//
// One transfer is accepted per clock while the pipeline is not frozen by a stalled output.
// A result passes through five register stages: date clamp and table lookup, the
// reciprocal multiply for the century count, the day sum, the day-to-seconds multiply,
// and the saturating output register.
// Reset (rst_n low at a clock edge) clears the stage valid bits only; data is not reset.
// When the output holds a result that is stalled, the whole pipeline freezes and in_stall
// rises in the same cycle, so nothing is dropped or repeated.

module calendar_to_epoch_seconds
  import c2e_pkg::*;
#(
  parameter int YEAR_BITS = YEAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [YEAR_BITS-1:0] in_year,
  input  logic [MONTH_W-1:0]   in_month,
  input  logic [DAY_W-1:0]     in_day,
  input  logic [HOUR_W-1:0]    in_hour,
  input  logic [MINUTE_W-1:0]  in_minute,
  input  logic [SECOND_W-1:0]  in_second,
  input  logic [NS_W-1:0]      in_nanosecond,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SECS_W-1:0]    out_epoch_seconds,
  output logic [NS_W-1:0]      out_nanoseconds_out
);

  // Width of (year - 1) / 4.
  localparam int Q4_W    = YEAR_BITS - 2;
  // (year - 1) / 100 is computed as ((year - 1) / 4) / 25 by a multiply with
  // ceil(2^RS / 25). The rounding error 25 - (2^RS mod 25) never exceeds
  // 2^(RS - Q4_W) = 32, so the quotient is exact for every Q4_W-bit operand.
  localparam int RS      = Q4_W + 5;
  localparam int RM_W    = RS - 4;
  localparam longint unsigned RECIP = ((64'd1 << RS) + 64'd24) / 64'd25;
  localparam int PROD_W  = Q4_W + RM_W;
  localparam int Q100_W  = Q4_W - 4;
  // Days since the epoch stay below 366 * 2^YEAR_BITS.
  localparam int DAYS_W  = YEAR_BITS + 9;
  localparam int DPROD_W = DAYS_W + DAY_SECS_ODD_W;
  localparam int FULL_RAW = DPROD_W + DAY_SECS_SHIFT + 1;
  localparam int FULL_W  = (FULL_RAW > SECS_W + 1) ? FULL_RAW : SECS_W + 1;
  localparam int LOW_W   = 7;

  logic en;

  // Stage 1: clamp, month table, time of day.
  logic                 v1_r;
  logic [YEAR_BITS-1:0] s1_yo_r;
  logic [Q4_W-1:0]      s1_q4_r;
  logic [LOW_W-1:0]     s1_ym1lo_r;
  logic                 s1_y4_r;
  logic                 s1_late_r;
  doy_t                 s1_dm_r;
  logic [TOD_W-1:0]     s1_tod_r;
  logic [NS_W-1:0]      s1_ns_r;

  // Stage 2: reciprocal product and the whole-year day count.
  logic                 v2_r;
  logic [PROD_W-1:0]    s2_p_r;
  logic [DAYS_W-1:0]    s2_da_r;
  logic [LOW_W-1:0]     s2_ym1lo_r;
  logic                 s2_y4_r;
  logic                 s2_late_r;
  doy_t                 s2_dm_r;
  logic [TOD_W-1:0]     s2_tod_r;
  logic [NS_W-1:0]      s2_ns_r;

  // Stage 3: total day count.
  logic                 v3_r;
  logic [DAYS_W-1:0]    s3_days_r;
  logic [TOD_W-1:0]     s3_tod_r;
  logic [NS_W-1:0]      s3_ns_r;

  // Stage 4: days times 675.
  logic                 v4_r;
  logic [DPROD_W-1:0]   s4_prod_r;
  logic [TOD_W-1:0]     s4_tod_r;
  logic [NS_W-1:0]      s4_ns_r;

  // Stage 5: output register.
  logic                 v5_r;
  logic [SECS_W-1:0]    s5_secs_r;
  logic [NS_W-1:0]      s5_ns_r;

  // The pipeline advances unless a finished result is held by the receiver.
  assign en       = !(v5_r && out_stall);
  assign in_stall = !en;

  // Stage 1 logic.
  logic                 s1_early;
  logic [YEAR_BITS-1:0] s1_year;
  logic [YEAR_BITS-1:0] s1_ym1;
  logic [MONTH_W-1:0]   s1_midx;
  logic [DAY_W-1:0]     s1_dm1;
  doy_t                 s1_dm_nxt;
  logic [TOD_W-1:0]     s1_tod_nxt;
  logic                 s1_late_nxt;

  always_comb begin
    s1_early = in_year < YEAR_BITS'(EPOCH_YEAR);
    s1_year  = s1_early ? YEAR_BITS'(EPOCH_YEAR) : in_year;
    s1_ym1   = s1_year - YEAR_BITS'(1);
    // Months outside 1..12, and every date before the epoch, count as January.
    if (s1_early || in_month == '0 || in_month > MONTH_W'(MONTHS)) begin
      s1_midx = '0;
    end else begin
      s1_midx = in_month - MONTH_W'(1);
    end
    s1_late_nxt = s1_midx >= MONTH_W'(LEAP_MONTH - 1);
    // Days outside 1..31 count as the first.
    if (s1_early || in_day == '0 || in_day > DAY_W'(31)) begin
      s1_dm1 = '0;
    end else begin
      s1_dm1 = in_day - DAY_W'(1);
    end
    s1_dm_nxt  = days_before_month(s1_midx) + DOY_W'(s1_dm1);
    s1_tod_nxt = TOD_W'(in_hour) * TOD_W'(SECS_PER_HOUR)
               + TOD_W'(in_minute) * TOD_W'(SECS_PER_MIN)
               + TOD_W'(in_second);
  end

  // Stage 2 logic.
  logic [PROD_W-1:0] s2_p_nxt;
  logic [DAYS_W-1:0] s2_da_nxt;

  always_comb begin
    s2_p_nxt  = PROD_W'(s1_q4_r) * PROD_W'(RECIP[RM_W-1:0]);
    s2_da_nxt = DAYS_W'(s1_yo_r) * DAYS_W'(DAYS_PER_YEAR)
              + DAYS_W'(s1_q4_r) - DAYS_W'(Q4_BASE);
  end

  // Stage 3 logic: century counts, leap test and the day sum.
  logic [Q100_W-1:0] s3_q100;
  logic [Q100_W-1:0] s3_q400;
  logic [LOW_W-1:0]  s3_r100;
  logic              s3_cent;
  logic              s3_leap;
  logic [DAYS_W-1:0] s3_days_nxt;

  always_comb begin
    s3_q100 = s2_p_r[RS +: Q100_W];
    s3_q400 = s3_q100 >> 2;
    // Remainder of (year - 1) by 100; a remainder of 99 means the year itself
    // is a multiple of 100, and then a multiple of 400 when the quotient is 3 mod 4.
    s3_r100 = s2_ym1lo_r - LOW_W'(LOW_W'(s3_q100) * LOW_W'(100));
    s3_cent = s3_r100 == LOW_W'(99);
    s3_leap = s2_y4_r && (!s3_cent || s3_q100[1:0] == 2'b11);
    s3_days_nxt = s2_da_r - DAYS_W'(s3_q100) + DAYS_W'(Q100_BASE)
                + DAYS_W'(s3_q400) - DAYS_W'(Q400_BASE)
                + DAYS_W'(s2_dm_r) + DAYS_W'(s3_leap && s2_late_r);
  end

  // Stage 4 and 5 logic.
  logic [DPROD_W-1:0] s4_prod_nxt;
  logic [FULL_W-1:0]  s5_full;
  logic [SECS_W-1:0]  s5_secs_nxt;

  always_comb begin
    s4_prod_nxt = DPROD_W'(s3_days_r) * DPROD_W'(DAY_SECS_ODD);
    s5_full     = (FULL_W'(s4_prod_r) << DAY_SECS_SHIFT) + FULL_W'(s4_tod_r);
    // Only reachable with years wider than 16 bits: clip at the largest count.
    if (s5_full[FULL_W-1:SECS_W] != '0) begin
      s5_secs_nxt = '1;
    end else begin
      s5_secs_nxt = s5_full[SECS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_yo_r    <= s1_year - YEAR_BITS'(EPOCH_YEAR);
      s1_q4_r    <= s1_ym1[YEAR_BITS-1:2];
      s1_ym1lo_r <= s1_ym1[LOW_W-1:0];
      s1_y4_r    <= s1_year[1:0] == 2'b00;
      s1_late_r  <= s1_late_nxt;
      s1_dm_r    <= s1_dm_nxt;
      s1_tod_r   <= s1_tod_nxt;
      s1_ns_r    <= in_nanosecond;

      s2_p_r     <= s2_p_nxt;
      s2_da_r    <= s2_da_nxt;
      s2_ym1lo_r <= s1_ym1lo_r;
      s2_y4_r    <= s1_y4_r;
      s2_late_r  <= s1_late_r;
      s2_dm_r    <= s1_dm_r;
      s2_tod_r   <= s1_tod_r;
      s2_ns_r    <= s1_ns_r;

      s3_days_r  <= s3_days_nxt;
      s3_tod_r   <= s2_tod_r;
      s3_ns_r    <= s2_ns_r;

      s4_prod_r  <= s4_prod_nxt;
      s4_tod_r   <= s3_tod_r;
      s4_ns_r    <= s3_ns_r;

      s5_secs_r  <= s5_secs_nxt;
      s5_ns_r    <= s4_ns_r;
    end
  end

  assign out_valid           = v5_r;
  assign out_epoch_seconds   = s5_secs_r;
  assign out_nanoseconds_out = s5_ns_r;

endmodule

// ===== bench/tb_calendar_to_epoch_seconds.sv =====
// Self-checking testbench for the calendar to epoch seconds converter.
`timescale 1ns / 1ps

module tb_calendar_to_epoch_seconds
  import c2e_pkg::*;
;

  localparam int CLK_PERIOD_NS = 12;
  localparam int RESET_CYCLES  = 11;
  // The pipeline is five stages deep; a few more cycles let any stray result show up.
  localparam int SETTLE_CYCLES = 12;
  // Many times the slowest correct run of roughly 1450 transfers.
  localparam int TIMEOUT_NS    = 5_000_000;

  localparam int          SECS_PER_DAY = 86400;
  localparam longint      SECONDS_CAP  = (64'd1 << SECS_W) - 1;
  localparam logic [NS_W-1:0] NS_ALL_ONES = '1;
  localparam int          NS_TOP       = 999_999_999;

  // Days elapsed in a common year before the first of each month.
  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // One broken-down date and time as presented on the input channel.
  typedef struct {
    logic [YEAR_BITS_DEF-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic [HOUR_W-1:0]        hour;
    logic [MINUTE_W-1:0]      minute;
    logic [SECOND_W-1:0]      second;
    logic [NS_W-1:0]          nanosecond;
  } date_time_t;

  // The timestamp the converter should return for one date.
  typedef struct {
    logic [SECS_W-1:0] seconds;
    logic [NS_W-1:0]   nanos;
  } timestamp_t;

  logic                     clk;
  logic                     rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [YEAR_BITS_DEF-1:0] in_year = '0;
  logic [MONTH_W-1:0]       in_month = '0;
  logic [DAY_W-1:0]         in_day = '0;
  logic [HOUR_W-1:0]        in_hour = '0;
  logic [MINUTE_W-1:0]      in_minute = '0;
  logic [SECOND_W-1:0]      in_second = '0;
  logic [NS_W-1:0]          in_nanosecond = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [SECS_W-1:0]        out_epoch_seconds;
  logic [NS_W-1:0]          out_nanoseconds_out;

  // Timestamps still owed by the converter, oldest first.
  timestamp_t awaited_stamps [$];

  int mismatches   = 0;
  int dates_sent   = 0;
  int stamps_seen  = 0;
  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int gap_pct      = 0;
  int stall_pct    = 0;

  calendar_to_epoch_seconds dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_year             (in_year),
    .in_month            (in_month),
    .in_day              (in_day),
    .in_hour             (in_hour),
    .in_minute           (in_minute),
    .in_second           (in_second),
    .in_nanosecond       (in_nanosecond),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_epoch_seconds   (out_epoch_seconds),
    .out_nanoseconds_out (out_nanoseconds_out)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_calendar_to_epoch_seconds: errors");
    $finish;
  end

  // Seconds since the epoch for one date. Dates before the epoch year collapse to the
  // first of January 1970, while the time of day is still added unchecked. Months and
  // days out of range fall back to one, and a day past the end of a short month simply
  // runs on into the next month.
  function automatic logic [SECS_W-1:0] unix_seconds_of(input date_time_t dt);
    longint y;
    longint mon;
    longint dom;
    longint days;
    longint secs;
    y   = longint'(dt.year);
    mon = longint'(dt.month);
    dom = longint'(dt.day);
    if (y < EPOCH_YEAR) begin
      y   = EPOCH_YEAR;
      mon = 1;
      dom = 1;
    end
    // Whole years since the epoch plus the leap days of the 4, 100 and 400 year rules,
    // counted up to the end of the previous year.
    days = 365 * (y - EPOCH_YEAR)
         + ((y - 1) / 4   - (EPOCH_YEAR - 1) / 4)
         - ((y - 1) / 100 - (EPOCH_YEAR - 1) / 100)
         + ((y - 1) / 400 - (EPOCH_YEAR - 1) / 400);
    if (mon < 1 || mon > 12) begin
      mon = 1;
    end
    days += MONTH_START[mon - 1];
    // The current year's leap day only counts once February is over.
    if (mon >= 3 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) begin
      days += 1;
    end
    if (dom < 1 || dom > 31) begin
      dom = 1;
    end
    days += dom - 1;
    secs = days * SECS_PER_DAY + longint'(dt.hour) * 3600
         + longint'(dt.minute) * 60 + longint'(dt.second);
    if (secs > SECONDS_CAP) begin
      secs = SECONDS_CAP;
    end
    return secs[SECS_W-1:0];
  endfunction

  function automatic date_time_t make_date(input int y, input int mon, input int dom,
                                           input int hh, input int mm, input int ss,
                                           input int ns);
    date_time_t dt;
    dt.year       = y[YEAR_BITS_DEF-1:0];
    dt.month      = mon[MONTH_W-1:0];
    dt.day        = dom[DAY_W-1:0];
    dt.hour       = hh[HOUR_W-1:0];
    dt.minute     = mm[MINUTE_W-1:0];
    dt.second     = ss[SECOND_W-1:0];
    dt.nanosecond = ns[NS_W-1:0];
    return dt;
  endfunction

  // Random dates: mostly sensible calendar dates so the leap and month logic is exercised,
  // with a share of full-range years, pre-epoch years and out-of-range fields mixed in.
  function automatic date_time_t random_date();
    date_time_t dt;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      dt.year = YEAR_BITS_DEF'($urandom_range(2500, EPOCH_YEAR));
    end else if (pick < 85) begin
      dt.year = YEAR_BITS_DEF'($urandom_range((1 << YEAR_BITS_DEF) - 1, 0));
    end else begin
      dt.year = YEAR_BITS_DEF'($urandom_range(EPOCH_YEAR - 1, 0));
    end
    dt.month  = MONTH_W'(($urandom_range(99) < 85) ? $urandom_range(12, 1)
                                                   : $urandom_range(15, 0));
    dt.day    = DAY_W'(($urandom_range(99) < 85) ? $urandom_range(31, 1)
                                                 : $urandom_range(63, 0));
    dt.hour   = HOUR_W'(($urandom_range(99) < 70) ? $urandom_range(23, 0)
                                                  : $urandom_range(31, 0));
    dt.minute = MINUTE_W'(($urandom_range(99) < 70) ? $urandom_range(59, 0)
                                                    : $urandom_range(63, 0));
    dt.second = SECOND_W'(($urandom_range(99) < 70) ? $urandom_range(59, 0)
                                                    : $urandom_range(63, 0));
    if ($urandom_range(99) < 90) begin
      dt.nanosecond = NS_W'($urandom_range(NS_TOP, 0));
    end else begin
      dt.nanosecond = NS_W'($urandom());
    end
    return dt;
  endfunction

  // Presents one date on the input channel and returns at the edge where the transfer
  // happens. The valid line is only lowered during a random hold-off, so back-to-back
  // transfers keep it high without a second assignment in the same time step.
  task automatic send_date(input date_time_t dt);
    timestamp_t want;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_year       <= dt.year;
    in_month      <= dt.month;
    in_day        <= dt.day;
    in_hour       <= dt.hour;
    in_minute     <= dt.minute;
    in_second     <= dt.second;
    in_nanosecond <= dt.nanosecond;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    want.seconds = unix_seconds_of(dt);
    want.nanos   = dt.nanosecond;
    awaited_stamps.push_back(want);
    dates_sent++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] result %0d: %s got %0d, expected %0d", $realtime, stamps_seen, what,
             got, want);
    mismatches++;
  endtask

  // The receiver stalls at random; the rate is set per phase of the run.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Every result transfer is matched against the oldest timestamp still owed.
  always @(posedge clk) begin : check_results
    timestamp_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_stamps.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_epoch_seconds), '0);
      end else begin
        want = awaited_stamps.pop_front();
        if (out_epoch_seconds !== want.seconds) begin
          report_mismatch("epoch_seconds", 64'(out_epoch_seconds), 64'(want.seconds));
        end
        if (out_nanoseconds_out !== want.nanos) begin
          report_mismatch("nanoseconds_out", 64'(out_nanoseconds_out), 64'(want.nanos));
        end
      end
      stamps_seen++;
    end
  end

  // Years before the epoch, including zero and the year just before it, must land on
  // the epoch day while keeping the unchecked time of day.
  task automatic test_epoch_clamp();
    send_date(make_date(0, 15, 63, 0, 0, 0, 0));
    send_date(make_date(EPOCH_YEAR - 1, 7, 20, 31, 63, 63, NS_TOP));
    send_date(make_date(EPOCH_YEAR, 1, 1, 0, 0, 0, 0));
    send_date(make_date(EPOCH_YEAR, 0, 0, 12, 30, 45, 1));
  endtask

  // Leap years under each rule, on either side of the end of February.
  task automatic test_leap_rules();
    send_date(make_date(1972, 2, 29, 23, 59, 59, 0));
    send_date(make_date(1972, 3, 1, 0, 0, 0, 0));
    send_date(make_date(2000, 3, 1, 0, 0, 0, 0));
    send_date(make_date(2100, 3, 1, 0, 0, 0, 0));
    send_date(make_date(2400, 12, 31, 23, 59, 59, 0));
    send_date(make_date(2023, 3, 1, 0, 0, 0, 0));
  endtask

  // Months and days outside the calendar fall back to one; a day past a short month's
  // end is not rejected and counts forward.
  task automatic test_month_day_fallback();
    send_date(make_date(2024, 13, 10, 0, 0, 0, 0));
    send_date(make_date(2024, 0, 10, 0, 0, 0, 0));
    send_date(make_date(2024, 5, 32, 0, 0, 0, 0));
    send_date(make_date(2024, 5, 0, 0, 0, 0, 0));
    send_date(make_date(2024, 14, 63, 6, 0, 0, 0));
    send_date(make_date(2023, 2, 31, 0, 0, 0, 0));
  endtask

  // The widest year and the largest time of day give the biggest second count; the
  // nanosecond field is pushed to its top value and past the one-second mark.
  task automatic test_field_extremes();
    send_date(make_date(65535, 12, 31, 31, 63, 63, int'(NS_ALL_ONES)));
    send_date(make_date(65535, 1, 1, 0, 0, 0, 0));
    send_date(make_date(32768, 6, 15, 0, 0, 0, NS_TOP));
    send_date(make_date(2038, 1, 19, 3, 14, 8, 536_870_912));
  endtask

  task automatic test_random_dates(input int count);
    for (int i = 0; i < count; i++) begin
      send_date(random_date());
    end
  endtask

  // The sender goes quiet until every owed timestamp has come back, then resumes.
  task automatic test_hold_until_drained();
    test_random_dates(8);
    in_valid <= 1'b0;
    while (awaited_stamps.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
    test_random_dates(8);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First mix: the sender pauses now and then, the receiver stalls most of the time.
    gap_pct   = 33;
    stall_pct = 78;
    test_epoch_clamp();
    test_leap_rules();
    test_month_day_fallback();
    test_field_extremes();
    test_random_dates(460);

    // Second mix: the roles swap.
    gap_pct   = 78;
    stall_pct = 33;
    test_random_dates(460);

    // Last mix: full rate in both directions, with one pause that empties the pipeline.
    gap_pct   = 0;
    stall_pct = 0;
    test_random_dates(240);
    test_hold_until_drained();
    test_random_dates(240);

    in_valid <= 1'b0;
    while (awaited_stamps.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d dates and checked %0d timestamps, %0d mismatches.",
             dates_sent, stamps_seen, mismatches);
    $display("Covered epoch clamping, leap rules, field fallbacks, extremes and random dates.");
    if (mismatches == 0) begin
      $display("tb_calendar_to_epoch_seconds: clean");
    end else begin
      $display("tb_calendar_to_epoch_seconds: errors");
    end
    $finish;
  end

endmodule
